>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file ppc_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PPC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ppc_pkg.sv
// Shared types and constants for the palette pixel compositor.
// No dependencies.
package ppc_pkg;

  localparam int IDX_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int COORD_W    = 10;
  localparam int ADDR_W     = 15;
  localparam int HEIGHT_W   = 11;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [MODE_W-1:0] DISPOSAL_RESTORE_BG = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN,
    CFG_Y_ORIGIN,
    CFG_FRAME_HEIGHT,
    CFG_DISPOSAL_MODE,
    CFG_TRANSPARENT_INDEX,
    CFG_BACKGROUND_INDEX,
    CFG_LINE_TRANSPARENCY,
    CFG_DROP_FRAME
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0]  x_origin;
    logic [COORD_W-1:0]  y_origin;
    logic [HEIGHT_W-1:0] frame_height;
    logic [MODE_W-1:0]   disposal_mode;
    logic [IDX_W-1:0]    transparent_index;
    logic [IDX_W-1:0]    background_index;
    logic                line_transparency;
    logic                drop_frame;
  } cfg_t;

  typedef struct packed {
    logic               pal_we;
    logic               pal_re;
    logic [IDX_W-1:0]   pal_idx;
    logic [COLOR_W-1:0] pal_color;
    logic               write_valid;
    logic               write_buffer;
    logic [ADDR_W-1:0]  pixel_address;
    logic               frame_complete;
    logic               frame_posted;
    logic               frame_had_transparency;
  } cmd_t;

  typedef struct packed {
    logic               write_valid;
    logic               write_buffer;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               frame_complete;
    logic               frame_posted;
    logic               frame_had_transparency;
  } res_t;

endpackage

>>> hw/rtl/ppc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module ppc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ppc_fifo.sv
// Small register FIFO carrying a packed type.
// No dependencies.
module ppc_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  T                           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output T                           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [LW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == LW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign level_o = cnt_q;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + LW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/ppc_front.sv
// Front end: accepts items, clips and classifies pixels, tracks frame state.
// Depends on ppc_pkg.
module ppc_front
  import ppc_pkg::*;
#(
  parameter int DISP_WIDTH   = 240,
  parameter int DISP_HEIGHT  = 135,
  parameter int PALETTE_SIZE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               push,
  output logic               full,
  input  logic               func_i,
  input  logic [IDX_W-1:0]   index_i,
  input  logic [COLOR_W-1:0] palette_color_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] column_i,
  input  logic               last_in_line_i,
  output logic               cmd_push_o,
  output cmd_t               cmd_o,
  input  logic               cmd_full_i
);

  localparam int PROD_W = 2 * HEIGHT_W;

  logic                draw_buffer_q, draw_buffer_d;
  logic                saw_q, saw_d;
  logic                accept;
  logic [HEIGHT_W-1:0] y, x;
  logic                line_kept, restore_bg, transparent_line;
  logic [IDX_W-1:0]    pix;
  logic                pix_ok, write_valid, last_row, complete;
  logic [PROD_W-1:0]   prod;

  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;

  always_comb begin
    y = HEIGHT_W'(cfg_i.y_origin) + HEIGHT_W'(row_i);
    x = HEIGHT_W'(cfg_i.x_origin) + HEIGHT_W'(column_i);
    line_kept = (HEIGHT_W'(cfg_i.x_origin) < HEIGHT_W'(DISP_WIDTH))
                && (y < HEIGHT_W'(DISP_HEIGHT));
    restore_bg       = (cfg_i.disposal_mode == DISPOSAL_RESTORE_BG);
    transparent_line = cfg_i.line_transparency && !restore_bg;
    pix = (restore_bg && index_i == cfg_i.transparent_index)
          ? cfg_i.background_index : index_i;
    pix_ok = ((IDX_W + 1)'(pix) < (IDX_W + 1)'(PALETTE_SIZE));
    write_valid = func_i && line_kept && (x < HEIGHT_W'(DISP_WIDTH))
                  && !(transparent_line && pix == cfg_i.transparent_index);
    prod = PROD_W'(y) * PROD_W'(DISP_WIDTH);
    last_row = (cfg_i.frame_height != '0)
               && (HEIGHT_W'(row_i) == cfg_i.frame_height - HEIGHT_W'(1));
    complete = func_i && line_kept && last_in_line_i && last_row;
  end

  always_comb begin
    saw_d         = saw_q;
    draw_buffer_d = draw_buffer_q;
    if (func_i && line_kept && transparent_line) begin
      saw_d = 1'b1;
    end
    cmd_o.frame_had_transparency = complete && saw_d;
    if (complete) begin
      saw_d         = 1'b0;
      draw_buffer_d = !draw_buffer_q;
    end
    cmd_o.pal_we         = !func_i && ((IDX_W + 1)'(index_i) < (IDX_W + 1)'(PALETTE_SIZE));
    cmd_o.pal_re         = write_valid && pix_ok;
    cmd_o.pal_idx        = func_i ? pix : index_i;
    cmd_o.pal_color      = palette_color_i;
    cmd_o.write_valid    = write_valid;
    cmd_o.write_buffer   = draw_buffer_q;
    cmd_o.pixel_address  = write_valid
                           ? ADDR_W'(prod[ADDR_W-1:0] + ADDR_W'(x)) : '0;
    cmd_o.frame_complete = complete;
    cmd_o.frame_posted   = complete && !cfg_i.drop_frame;
  end

  assign cmd_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_buffer_q <= 1'b0;
      saw_q         <= 1'b0;
    end else if (accept) begin
      draw_buffer_q <= draw_buffer_d;
      saw_q         <= saw_d;
    end
  end

endmodule

>>> hw/rtl/ppc_back.sv
// Back end: palette write or lookup, then result assembly.
// Depends on ppc_pkg and ppc_ram.
module ppc_back
  import ppc_pkg::*;
#(
  parameter int PALETTE_SIZE = 256,
  parameter int OUT_DEPTH    = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_empty_i,
  input  cmd_t                           cmd_i,
  output logic                           cmd_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level_i,
  output logic                           res_push_o,
  output res_t                           res_o
);

  localparam int AW = $clog2(PALETTE_SIZE);
  localparam int LW = $clog2(OUT_DEPTH + 1);

  logic               b1_valid_q;
  cmd_t               b1_cmd_q;
  logic [COLOR_W-1:0] rdata;
  logic [LW:0]        committed;

  assign committed = (LW + 1)'(out_level_i) + (LW + 1)'(b1_valid_q);
  assign cmd_pop_o = !cmd_empty_i && (committed < (LW + 1)'(OUT_DEPTH));

  ppc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_SIZE)
  ) u_palette (
    .clk_i   (clk_i),
    .en_i    (cmd_pop_o && (cmd_i.pal_we || cmd_i.pal_re)),
    .we_i    (cmd_i.pal_we),
    .addr_i  (cmd_i.pal_idx[AW-1:0]),
    .wdata_i (cmd_i.pal_color),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= cmd_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      b1_cmd_q <= cmd_i;
    end
  end

  always_comb begin
    res_push_o                   = b1_valid_q;
    res_o.write_valid            = b1_cmd_q.write_valid;
    res_o.write_buffer           = b1_cmd_q.write_buffer;
    res_o.pixel_address          = b1_cmd_q.pixel_address;
    res_o.pixel_color            = b1_cmd_q.pal_re ? rdata : '0;
    res_o.frame_complete         = b1_cmd_q.frame_complete;
    res_o.frame_posted           = b1_cmd_q.frame_posted;
    res_o.frame_had_transparency = b1_cmd_q.frame_had_transparency;
  end

endmodule

>>> hw/rtl/palette_pixel_compositor.sv
// Top level of the palette pixel compositor: config registers, front, queues, back.
// Depends on ppc_pkg, ppc_fifo, ppc_front, ppc_back.
//
//  port group    | direction | handshake
//  --------------+-----------+---------------------------------
//  item input    | in        | push / full
//  result output | out       | empty / pop
//  config write  | in        | cfg_valid_i / cfg_ready_o
//
// One item per cycle while the result side pops; an item passes the command queue,
// back-end register and result queue, and uses the palette RAM port at most once.
// A full result queue stalls the back end; a full command queue raises full.
// Reset is asynchronous; queues empty, draw buffer 0, registers to defaults.
module palette_pixel_compositor
  import ppc_pkg::*;
#(
  parameter int DISP_WIDTH   = 240,
  parameter int DISP_HEIGHT  = 135,
  parameter int PALETTE_SIZE = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic                  func_i,
  input  logic [IDX_W-1:0]      index_i,
  input  logic [COLOR_W-1:0]    palette_color_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic [COORD_W-1:0]    column_i,
  input  logic                  last_in_line_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  write_valid_o,
  output logic                  write_buffer_o,
  output logic [ADDR_W-1:0]     pixel_address_o,
  output logic [COLOR_W-1:0]    pixel_color_o,
  output logic                  frame_complete_o,
  output logic                  frame_posted_o,
  output logic                  frame_had_transparency_o
);

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  cfg_t cfg_q, cfg_d;
  cmd_t front_cmd, back_cmd;
  res_t back_res, out_res;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty, res_push;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_level;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_level;
  logic                           out_full;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_X_ORIGIN:          cfg_d.x_origin          = cfg_data_i[COORD_W-1:0];
        CFG_Y_ORIGIN:          cfg_d.y_origin          = cfg_data_i[COORD_W-1:0];
        CFG_FRAME_HEIGHT:      cfg_d.frame_height      = cfg_data_i[HEIGHT_W-1:0];
        CFG_DISPOSAL_MODE:     cfg_d.disposal_mode     = cfg_data_i[MODE_W-1:0];
        CFG_TRANSPARENT_INDEX: cfg_d.transparent_index = cfg_data_i[IDX_W-1:0];
        CFG_BACKGROUND_INDEX:  cfg_d.background_index  = cfg_data_i[IDX_W-1:0];
        CFG_LINE_TRANSPARENCY: cfg_d.line_transparency = cfg_data_i[0];
        CFG_DROP_FRAME:        cfg_d.drop_frame        = cfg_data_i[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin          <= '0;
      cfg_q.y_origin          <= '0;
      cfg_q.frame_height      <= HEIGHT_W'(1);
      cfg_q.disposal_mode     <= '0;
      cfg_q.transparent_index <= '0;
      cfg_q.background_index  <= '0;
      cfg_q.line_transparency <= 1'b0;
      cfg_q.drop_frame        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ppc_front #(
    .DISP_WIDTH   (DISP_WIDTH),
    .DISP_HEIGHT  (DISP_HEIGHT),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .push            (push),
    .full            (full),
    .func_i          (func_i),
    .index_i         (index_i),
    .palette_color_i (palette_color_i),
    .row_i           (row_i),
    .column_i        (column_i),
    .last_in_line_i  (last_in_line_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (front_cmd),
    .cmd_full_i      (cmd_full)
  );

  ppc_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty),
    .level_o (cmd_level)
  );

  ppc_back #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .OUT_DEPTH    (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty || (cmd_level == '0)),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_level_i (out_level),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  ppc_fifo #(
    .T     (res_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push && !out_full),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty),
    .level_o (out_level)
  );

  assign write_valid_o            = out_res.write_valid;
  assign write_buffer_o           = out_res.write_buffer;
  assign pixel_address_o          = out_res.pixel_address;
  assign pixel_color_o            = out_res.pixel_color;
  assign frame_complete_o         = out_res.frame_complete;
  assign frame_posted_o           = out_res.frame_posted;
  assign frame_had_transparency_o = out_res.frame_had_transparency;

endmodule

>>> hw/rtl/ppc_checker.sv
// Port-level checker for the palette pixel compositor, bound to the top level.
// Depends on ppc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppc_checker
  import ppc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input logic                  write_valid_o,
  input logic [ADDR_W-1:0]     pixel_address_o,
  input logic [COLOR_W-1:0]    pixel_color_o,
  input logic                  frame_complete_o,
  input logic                  frame_posted_o,
  input logic                  frame_had_transparency_o
);

  `PPC_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |=> empty, "result queue not empty after reset")

  `PPC_ASSERT(a_frame_flags, clk_i, rst_ni, (!empty && !frame_complete_o) |-> (!frame_posted_o && !frame_had_transparency_o), "frame flags without frame completion")

  `PPC_ASSERT(a_no_write_zero, clk_i, rst_ni, (!empty && !write_valid_o) |-> (pixel_address_o == '0 && pixel_color_o == '0), "address or color set without a write")

  `PPC_ASSERT(a_result_held, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(pixel_address_o) && $stable(pixel_color_o)), "waiting result dropped or changed")

endmodule

bind palette_pixel_compositor ppc_checker u_ppc_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for palette_pixel_compositor: palette loads and pixel draws
// go in as push/full beats, framebuffer results come back as empty/pop beats and are
// checked against an in-bench predictor. Depends on ppc_pkg and the compositor RTL.
module testbench;
  import ppc_pkg::*;

  localparam int DISP_W      = 240;
  localparam int DISP_H      = 135;
  localparam int CLK_PERIOD  = 8;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int HOLD_PHASE  = 5;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_NS    = 10_000_000;

  typedef struct {
    logic               func;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               last;
  } pixel_item_t;

  bit                    clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  push;
  logic                  full;
  logic                  func_i;
  logic [IDX_W-1:0]      index_i;
  logic [COLOR_W-1:0]    palette_color_i;
  logic [COORD_W-1:0]    row_i;
  logic [COORD_W-1:0]    column_i;
  logic                  last_in_line_i;
  logic                  empty;
  logic                  pop;
  logic                  write_valid_o;
  logic                  write_buffer_o;
  logic [ADDR_W-1:0]     pixel_address_o;
  logic [COLOR_W-1:0]    pixel_color_o;
  logic                  frame_complete_o;
  logic                  frame_posted_o;
  logic                  frame_had_transparency_o;

  palette_pixel_compositor dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i),
    .push                     (push),
    .full                     (full),
    .func_i                   (func_i),
    .index_i                  (index_i),
    .palette_color_i          (palette_color_i),
    .row_i                    (row_i),
    .column_i                 (column_i),
    .last_in_line_i           (last_in_line_i),
    .empty                    (empty),
    .pop                      (pop),
    .write_valid_o            (write_valid_o),
    .write_buffer_o           (write_buffer_o),
    .pixel_address_o          (pixel_address_o),
    .pixel_color_o            (pixel_color_o),
    .frame_complete_o         (frame_complete_o),
    .frame_posted_o           (frame_posted_o),
    .frame_had_transparency_o (frame_had_transparency_o)
  );

  // predictor state
  logic [COLOR_W-1:0] palette_shadow [256];
  logic               draw_buf;
  logic               saw_transp;
  cfg_t               cfg_shadow;

  // stimulus state
  cfg_t        gen_cfg;
  bit          loaded [256];
  int          loaded_list [$];
  pixel_item_t pixel_backlog [$];
  res_t        fb_results_due [$];
  pixel_item_t cur_item;
  bit          offering;
  int          send_wait;
  int          sink_stall;
  int          hold_left;
  bit          hold_req;
  bit          src_gaps_on;
  bit          sink_gaps_on;

  int unsigned queued_cnt;
  int unsigned items_taken;
  int unsigned palette_loads;
  int unsigned fb_writes;
  int unsigned frames_done;
  int unsigned frames_dropped;
  int unsigned full_stalls;
  int unsigned mismatch_count;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("palette_pixel_compositor: mismatch");
    $finish;
  end

  function automatic int draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic res_t composite_pixel(pixel_item_t it);
    res_t        r;
    int unsigned y;
    int unsigned x;
    int unsigned pix;
    bit          transp_line;
    r = '0;
    r.write_buffer = draw_buf;
    if (!it.func) begin
      palette_shadow[it.index] = it.color;
    end else begin
      y = cfg_shadow.y_origin + it.row;
      if (cfg_shadow.x_origin < DISP_W && y < DISP_H) begin
        transp_line = cfg_shadow.line_transparency;
        pix = it.index;
        x = cfg_shadow.x_origin + it.column;
        if (cfg_shadow.disposal_mode == DISPOSAL_RESTORE_BG) begin
          if (pix == cfg_shadow.transparent_index) pix = cfg_shadow.background_index;
          transp_line = 1'b0;
        end
        if (transp_line) saw_transp = 1'b1;
        if (x < DISP_W && !(transp_line && pix == cfg_shadow.transparent_index)) begin
          r.write_valid = 1'b1;
          r.pixel_address = ADDR_W'(y * DISP_W + x);
          r.pixel_color = palette_shadow[pix];
        end
        if (it.last && cfg_shadow.frame_height != 0 &&
            it.row == cfg_shadow.frame_height - 1) begin
          r.frame_complete = 1'b1;
          r.frame_posted = !cfg_shadow.drop_frame;
          r.frame_had_transparency = saw_transp;
          saw_transp = 1'b0;
          draw_buf = !draw_buf;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // input side: take the beat, then offer the next item
  always @(posedge clk_i) begin : drv_accept
    if (rst_ni && push && !full) begin
      fb_results_due.push_back(composite_pixel(cur_item));
      offering = 1'b0;
      items_taken++;
      if (!cur_item.func) palette_loads++;
      if (src_gaps_on) send_wait = draw_gap();
    end
    if (rst_ni && push && full) full_stalls++;
  end

  always @(negedge clk_i) begin : drv_offer
    if (rst_ni && !offering) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (pixel_backlog.size() != 0) begin
        cur_item = pixel_backlog.pop_front();
        offering = 1'b1;
        func_i          <= cur_item.func;
        index_i         <= cur_item.index;
        palette_color_i <= cur_item.color;
        row_i           <= cur_item.row;
        column_i        <= cur_item.column;
        last_in_line_i  <= cur_item.last;
      end
    end
    push <= offering;
  end

  // result side: check each beat against the oldest prediction
  always @(posedge clk_i) begin : mon_sample
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (fb_results_due.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatch_count++;
      end else begin
        want = fb_results_due.pop_front();
        check_field("write_valid", want.write_valid, write_valid_o);
        check_field("write_buffer", want.write_buffer, write_buffer_o);
        check_field("pixel_address", want.pixel_address, pixel_address_o);
        check_field("pixel_color", want.pixel_color, pixel_color_o);
        check_field("frame_complete", want.frame_complete, frame_complete_o);
        check_field("frame_posted", want.frame_posted, frame_posted_o);
        check_field("frame_had_transparency", want.frame_had_transparency,
                    frame_had_transparency_o);
        if (want.write_valid) fb_writes++;
        if (want.frame_complete) frames_done++;
        if (want.frame_complete && !want.frame_posted) frames_dropped++;
      end
      if (sink_gaps_on) sink_stall = draw_gap();
    end
  end

  always @(negedge clk_i) begin : mon_pop
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_X_ORIGIN:          cfg_shadow.x_origin = val[COORD_W-1:0];
      CFG_Y_ORIGIN:          cfg_shadow.y_origin = val[COORD_W-1:0];
      CFG_FRAME_HEIGHT:      cfg_shadow.frame_height = val[HEIGHT_W-1:0];
      CFG_DISPOSAL_MODE:     cfg_shadow.disposal_mode = val[MODE_W-1:0];
      CFG_TRANSPARENT_INDEX: cfg_shadow.transparent_index = val[IDX_W-1:0];
      CFG_BACKGROUND_INDEX:  cfg_shadow.background_index = val[IDX_W-1:0];
      CFG_LINE_TRANSPARENCY: cfg_shadow.line_transparency = val[0];
      CFG_DROP_FRAME:        cfg_shadow.drop_frame = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(cfg_t c);
    write_reg(CFG_X_ORIGIN, c.x_origin);
    write_reg(CFG_Y_ORIGIN, c.y_origin);
    write_reg(CFG_FRAME_HEIGHT, c.frame_height);
    write_reg(CFG_DISPOSAL_MODE, c.disposal_mode);
    write_reg(CFG_TRANSPARENT_INDEX, c.transparent_index);
    write_reg(CFG_BACKGROUND_INDEX, c.background_index);
    write_reg(CFG_LINE_TRANSPARENCY, c.line_transparency);
    write_reg(CFG_DROP_FRAME, c.drop_frame);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    gen_cfg = c;
  endtask

  task automatic drain();
    while (pixel_backlog.size() != 0 || offering || fb_results_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic queue_item(logic func, logic [IDX_W-1:0] index, logic [COLOR_W-1:0] color,
                            int unsigned row, int unsigned column, logic last);
    pixel_item_t it;
    it.func   = func;
    it.index  = index;
    it.color  = color;
    it.row    = COORD_W'(row);
    it.column = COORD_W'(column);
    it.last   = last;
    if (!func && !loaded[index]) begin
      loaded[index] = 1'b1;
      loaded_list.push_back(index);
    end
    pixel_backlog.push_back(it);
    queued_cnt++;
  endtask

  // pixel indices come only from palette entries already loaded
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 9) < 3 && loaded[gen_cfg.transparent_index])
      return gen_cfg.transparent_index;
    return IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  task automatic queue_palette_load();
    queue_item(1'b0, IDX_W'($urandom_range(0, 255)), COLOR_W'($urandom),
               $urandom_range(0, 1023), $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_frame();
    int unsigned rows [$];
    int unsigned fh;
    int unsigned n;
    int unsigned start;
    int unsigned sel;
    fh = gen_cfg.frame_height;
    if (fh >= 1 && fh <= 40) begin
      for (int r = 0; r < fh; r++) rows.push_back(r);
    end else begin
      rows.push_back($urandom_range(0, 1023));
      rows.push_back($urandom_range(0, 134));
      if (fh >= 1 && fh <= 1024) rows.push_back(fh - 1);
    end
    foreach (rows[k]) begin
      n = $urandom_range(1, 6);
      sel = $urandom_range(0, 3);
      if (sel < 2) start = $urandom_range(0, 20);
      else if (sel == 2) start = $urandom_range(0, 239);
      else start = $urandom_range(200, 1023);
      for (int c = 0; c < n; c++) begin
        if ($urandom_range(0, 11) == 0) queue_palette_load();
        queue_item(1'b1, pick_index(), COLOR_W'($urandom), rows[k], start + c, c == n - 1);
      end
    end
  endtask

  task automatic queue_noise();
    if ($urandom_range(0, 3) == 0) queue_palette_load();
    else queue_item(1'b1, pick_index(), COLOR_W'($urandom), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
  endtask

  function automatic cfg_t make_cfg(int p);
    cfg_t        c;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) c.x_origin = $urandom_range(0, 200);
    else if (r < 8) c.x_origin = $urandom_range(220, 239);
    else if (r == 8) c.x_origin = $urandom_range(240, 1023);
    else c.x_origin = $urandom_range(0, 1023);
    r = $urandom_range(0, 9);
    if (r < 6) c.y_origin = $urandom_range(0, 120);
    else if (r < 8) c.y_origin = $urandom_range(125, 134);
    else if (r == 8) c.y_origin = $urandom_range(135, 1023);
    else c.y_origin = $urandom_range(0, 1023);
    r = $urandom_range(0, 9);
    if (r < 7) c.frame_height = $urandom_range(1, 8);
    else if (r == 7) c.frame_height = $urandom_range(9, 40);
    else c.frame_height = $urandom_range(0, 2047);
    if ($urandom_range(0, 9) < 4) c.disposal_mode = DISPOSAL_RESTORE_BG;
    else c.disposal_mode = $urandom_range(0, 7);
    c.transparent_index = $urandom_range(0, 255);
    c.background_index = IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    c.line_transparency = $urandom_range(0, 1);
    c.drop_frame = $urandom_range(0, 1);
    case (p)
      0: begin
        c.x_origin = 0;
        c.y_origin = 0;
        c.frame_height = 1;
        c.disposal_mode = 0;
        c.line_transparency = 1'b1;
        c.drop_frame = 1'b0;
      end
      1: begin
        c.x_origin = 1023;
        c.y_origin = 1023;
        c.frame_height = 1024;
        c.disposal_mode = 7;
        c.transparent_index = 8'hFF;
        c.background_index = 8'h00;
        c.line_transparency = 1'b0;
        c.drop_frame = 1'b1;
      end
      2: begin
        c.x_origin = 239;
        c.y_origin = 134;
        c.frame_height = 1;
        c.disposal_mode = DISPOSAL_RESTORE_BG;
        c.transparent_index = 8'h00;
        c.background_index = 8'hFF;
      end
      3: c.frame_height = 0;
      4: begin
        c.y_origin = 0;
        c.frame_height = 2047;
      end
      6: begin
        c.x_origin = 0;
        c.y_origin = 0;
        c.frame_height = 1024;
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin : stimulus
    cfg_t        c;
    int unsigned made;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_X_ORIGIN;
    cfg_data_i      = '0;
    push            = 1'b0;
    pop             = 1'b0;
    func_i          = 1'b0;
    index_i         = '0;
    palette_color_i = '0;
    row_i           = '0;
    column_i        = '0;
    last_in_line_i  = 1'b0;
    cfg_shadow      = '0;
    cfg_shadow.frame_height = 1;
    draw_buf        = 1'b0;
    saw_transp      = 1'b0;
    src_gaps_on     = 1'b1;
    sink_gaps_on    = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: edges of the display, transparency, right-edge and line clipping
    c = '0;
    c.frame_height = 2;
    c.line_transparency = 1'b1;
    c.background_index = 8'hFF;
    configure(c);
    queue_item(1'b0, 8'h00, 16'hFFFF, 0, 0, 1'b0);
    queue_item(1'b0, 8'hFF, 16'h0000, 1023, 1023, 1'b1);
    queue_item(1'b0, 8'h55, 16'hA5A5, 0, 0, 1'b0);
    queue_item(1'b0, 8'hAA, 16'h5A5A, 0, 0, 1'b0);
    queue_item(1'b1, 8'hFF, 16'h0000, 0, 0, 1'b0);
    queue_item(1'b1, 8'h00, 16'h0000, 0, 1, 1'b0);
    queue_item(1'b1, 8'h55, 16'h0000, 0, 239, 1'b1);
    queue_item(1'b1, 8'hAA, 16'h0000, 0, 240, 1'b0);
    queue_item(1'b1, 8'h55, 16'hFFFF, 1, 1023, 1'b1);
    queue_item(1'b1, 8'hAA, 16'h0000, 1023, 0, 1'b1);
    queue_item(1'b1, 8'hFF, 16'h0000, 134, 0, 1'b0);
    queue_item(1'b1, 8'h00, 16'h0000, 1, 0, 1'b1);
    drain();

    // restore to background, dropped frame
    c.x_origin = 10;
    c.y_origin = 5;
    c.frame_height = 1;
    c.disposal_mode = DISPOSAL_RESTORE_BG;
    c.transparent_index = 8'h55;
    c.background_index = 8'hAA;
    c.drop_frame = 1'b1;
    configure(c);
    queue_item(1'b1, 8'h55, 16'h0000, 0, 0, 1'b0);
    queue_item(1'b1, 8'h00, 16'h0000, 0, 229, 1'b0);
    queue_item(1'b1, 8'hFF, 16'h0000, 0, 230, 1'b1);
    queue_item(1'b0, 8'h0F, 16'h0F0F, 0, 0, 1'b0);
    queue_item(1'b0, 8'hF0, 16'hF0F0, 0, 0, 1'b0);
    queue_item(1'b1, 8'h0F, 16'h0000, 200, 0, 1'b1);
    queue_item(1'b1, 8'hF0, 16'h0000, 0, 3, 1'b0);
    drain();

    // whole line off the right of the display
    c = '0;
    c.x_origin = 240;
    c.frame_height = 1;
    c.transparent_index = 8'hFF;
    configure(c);
    queue_item(1'b1, 8'h00, 16'h0000, 0, 0, 1'b1);
    queue_item(1'b1, 8'hFF, 16'h0000, 0, 0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(make_cfg(p));
      src_gaps_on = (p % 4 != 1) && (p != HOLD_PHASE);
      sink_gaps_on = (p % 4 != 2);
      // stall the result side long enough to back up into full
      if (p == HOLD_PHASE) hold_req = 1'b1;
      made = queued_cnt;
      while (queued_cnt - made < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) queue_frame();
        else queue_noise();
      end
    end
    drain();
    repeat (12) @(posedge clk_i);

    $display("covered %0d beats in (%0d palette loads), %0d framebuffer writes, %0d frames",
             items_taken, palette_loads, fb_writes, frames_done);
    $display("  %0d frames dropped, %0d config phases, %0d cycles held off by full",
             frames_dropped, PHASES + 3, full_stalls);
    if (mismatch_count == 0) begin
      $display("palette_pixel_compositor: match");
    end else begin
      $display("palette_pixel_compositor: mismatch");
    end
    $finish;
  end

endmodule
